FILE: design/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold unit.
// No dependencies; imported by every module of the block.
package sobel_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int CNT_LIMIT     = 1024;   // counter range of col/row

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int MAG_W   = 11;
    localparam int COORD_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] RST_THRESHOLD    = 11'd255;
    localparam logic [CFG_W-1:0] MIN_DIM          = 11'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_EDGE_THRESH  = 2'd2
    } t_cfg_idx;

    // frame geometry handed to the front end
    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
    } t_geom;

    // the eight outer pixels of a 3x3 window plus its top-left coordinate
    typedef struct packed {
        logic [PIX_W-1:0]   tl;
        logic [PIX_W-1:0]   ml;
        logic [PIX_W-1:0]   bl;
        logic [PIX_W-1:0]   tc;
        logic [PIX_W-1:0]   bc;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   mid;
        logic [PIX_W-1:0]   bot;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_window;

    // queue handshake from front to queue
    typedef struct packed {
        logic    push;
        t_window data;
    } t_push;

endpackage

FILE: design/sobel_front.sv
// Front end: raster counters, two line memories and the 3x3 window registers.
// Uses sobel_pkg; feeds complete windows into sobel_fifo.
module sobel_front
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_stall,
    input  t_geom              i_geom,
    input  logic [FIFO_CW-1:0] i_fifo_count,
    output t_push              o_push
);

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WMAX = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;

    logic               accept;
    logic [CFG_W-1:0]   w_clamp, h_clamp, w_last, h_last;
    logic               col_end, row_end;
    logic [AW-1:0]      idx;

    logic [COORD_W-1:0] r_col, r_row;
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;
    logic [AW-1:0]      r_s1_idx;
    logic [PIX_W-1:0]   r_top_q, r_mid_q;
    logic [PIX_W-1:0]   r_win [6];

    // mid_mem: previous row, top_mem: the row before it
    logic [PIX_W-1:0]   r_mid_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   r_top_mem [MAX_WIDTH];

    // space for the item in stage 1 and the one accepted now
    assign o_stall = ({1'b0, i_fifo_count} + {{FIFO_CW{1'b0}}, r_s1_valid})
                     >= (FIFO_CW+1)'(FIFO_DEPTH);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (i_geom.line_width < MIN_DIM) begin
            w_clamp = MIN_DIM;
        end else if (i_geom.line_width > CFG_W'(WMAX)) begin
            w_clamp = CFG_W'(WMAX);
        end else begin
            w_clamp = i_geom.line_width;
        end
        if (i_geom.frame_height < MIN_DIM) begin
            h_clamp = MIN_DIM;
        end else if (i_geom.frame_height > CFG_W'(CNT_LIMIT)) begin
            h_clamp = CFG_W'(CNT_LIMIT);
        end else begin
            h_clamp = i_geom.frame_height;
        end
        w_last  = w_clamp - 11'd1;
        h_last  = h_clamp - 11'd1;
        col_end = {1'b0, r_col} >= w_last;
        row_end = {1'b0, r_row} >= h_last;
        idx     = (32'(r_col) < MAX_WIDTH) ? AW'(r_col) : AW'(MAX_WIDTH - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 10'd1;
                end else begin
                    r_col <= r_col + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_pixel;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_idx <= idx;
        end
    end

    // line memories: read on accept, write back from stage 1. Consecutive
    // items never share an address since every row is at least 3 wide.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid_q <= r_mid_mem[idx];
            r_top_q <= r_top_mem[idx];
        end
        if (r_s1_valid) begin
            r_mid_mem[r_s1_idx] <= r_s1_pix;
            r_top_mem[r_s1_idx] <= r_mid_q;
        end
    end

    // window columns: [0..2] previous column, [3..5] the one before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_top_q;
            r_win[1] <= r_mid_q;
            r_win[2] <= r_s1_pix;
        end
    end

    always_comb begin
        o_push.push      = r_s1_valid && (r_s1_col >= 10'd2) && (r_s1_row >= 10'd2);
        o_push.data.tl   = r_win[3];
        o_push.data.ml   = r_win[4];
        o_push.data.bl   = r_win[5];
        o_push.data.tc   = r_win[0];
        o_push.data.bc   = r_win[2];
        o_push.data.top  = r_top_q;
        o_push.data.mid  = r_mid_q;
        o_push.data.bot  = r_s1_pix;
        o_push.data.col  = r_s1_col - 10'd2;
        o_push.data.row  = r_s1_row - 10'd2;
    end

endmodule

FILE: design/sobel_fifo.sv
// Short window queue between the front end and the gradient back end.
// Uses sobel_pkg for the entry type and depth.
module sobel_fifo
    import sobel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output t_window            o_head,
    output logic [FIFO_CW-1:0] o_count
);

    t_window              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic                 do_pop;

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && r_count == FIFO_CW'(FIFO_DEPTH)))
        else $error("window queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("window queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("window queue count lost a push");

endmodule

FILE: design/sobel_back.sv
// Back end: Sobel gradients, magnitude, threshold compare, output register.
// Uses sobel_pkg; drains windows from sobel_fifo.
module sobel_back
    import sobel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_win_valid,
    input  t_window            i_win,
    output logic               o_pop,
    input  logic [CFG_W-1:0]   i_threshold,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_is_edge,
    output logic [MAG_W-1:0]   o_magnitude,
    output logic [COORD_W-1:0] o_out_col,
    output logic [COORD_W-1:0] o_out_row
);

    logic [9:0]       gy_a, gy_b, gx_a, gx_b, gy, gx;
    logic [MAG_W-1:0] mag;
    logic             r_valid;

    // weights 1,2,1; each sum fits in 10 bits
    always_comb begin
        gy_a = 10'(i_win.tl) + {1'b0, i_win.tc, 1'b0} + 10'(i_win.top);
        gy_b = 10'(i_win.bl) + {1'b0, i_win.bc, 1'b0} + 10'(i_win.bot);
        gx_a = 10'(i_win.top) + {1'b0, i_win.mid, 1'b0} + 10'(i_win.bot);
        gx_b = 10'(i_win.tl) + {1'b0, i_win.ml, 1'b0} + 10'(i_win.bl);
        gy   = (gy_a >= gy_b) ? gy_a - gy_b : gy_b - gy_a;
        gx   = (gx_a >= gx_b) ? gx_a - gx_b : gx_b - gx_a;
        mag  = {1'b0, gx} + {1'b0, gy};
    end

    assign o_pop   = i_win_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_is_edge   <= mag >= i_threshold;
            o_magnitude <= mag;
            o_out_col   <= i_win.col;
            o_out_row   <= i_win.row;
        end
    end

endmodule

FILE: design/sobel_edge_threshold_unit.sv
// Top level of the Sobel edge threshold unit: configuration registers and
// the front end / window queue / back end chain. Uses sobel_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  pixel in | input     | i_valid / o_stall  | i_pixel
//  result   | output    | o_valid / i_stall  | o_is_edge, o_magnitude,
//           |           |                    | o_out_col, o_out_row
//  config   | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One pixel per cycle while o_stall is low; a result passes the line memory
// read, window queue and gradient register before o_valid rises.
// Pixels in the first two rows and columns of a frame give no result.
// Synchronous active-low reset clears counters, window and queue; the line
// memories are not cleared. The 4-entry queue absorbs output stalls; input
// stall rises when the queued windows plus the item in stage 1 reach 4.
module sobel_edge_threshold_unit
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_is_edge,
    output logic [MAG_W-1:0]     o_magnitude,
    output logic [COORD_W-1:0]   o_out_col,
    output logic [COORD_W-1:0]   o_out_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_line_width, r_frame_height, r_threshold;
    t_geom              geom;
    t_push              push;
    logic               pop, win_valid;
    t_window            win;
    logic [FIFO_CW-1:0] fifo_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold    <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_EDGE_THRESH:  r_threshold    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign geom.line_width   = r_line_width;
    assign geom.frame_height = r_frame_height;

    sobel_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_pixel      (i_pixel),
        .o_stall      (o_stall),
        .i_geom       (geom),
        .i_fifo_count (fifo_count),
        .o_push       (push)
    );

    sobel_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (win_valid),
        .o_head  (win),
        .o_count (fifo_count)
    );

    sobel_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .i_win       (win),
        .o_pop       (pop),
        .i_threshold (r_threshold),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_is_edge   (o_is_edge),
        .o_magnitude (o_magnitude),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row)
    );

endmodule
